// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a property holds on every clock while out of reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that a condition is never seen on a clock while out of reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	`ASSERT_CLK(label, clk, rst_n, !(cond), msg)

`endif

// ===== hdl/qoi_pkg.sv =====
// ----------------------------------------------------------------------------
// qoi_pkg
// Shared types and constants of the QOI-like pixel decoder.
// ----------------------------------------------------------------------------
package qoi_pkg;

	localparam int INDEX_ENTRIES_DEF  = 64;
	localparam int DIMENSION_BITS_DEF = 16;
	localparam int CFG_ADDR_W         = 1;
	localparam int CFG_DATA_W         = 16;

	localparam logic [CFG_ADDR_W-1:0] REG_WIDTH  = 1'b0;
	localparam logic [CFG_ADDR_W-1:0] REG_HEIGHT = 1'b1;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_marker;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [7:0]  alpha;
		logic [31:0] repeat_count;
		logic        image_complete;
		logic        truncated_error;
	} out_item_t;

endpackage

// ===== hdl/qoi_fifo.sv =====
// ----------------------------------------------------------------------------
// qoi_fifo
// Small two-entry queue that decouples the front end from the decode core.
// ----------------------------------------------------------------------------
module qoi_fifo #(
	parameter int WIDTH = 9
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             flush,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic             empty,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [2];
	logic             wp_q, rp_q;
	logic [1:0]       cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push && !full) mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
		end else if (flush) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
		end else begin
			if (push && !full) wp_q <= ~wp_q;
			if (pop && !empty) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push && !full) - 2'(pop && !empty);
		end
	end
endmodule

// ===== hdl/qoi_core.sv =====
// ----------------------------------------------------------------------------
// qoi_core
// Decode back end: opcode state, colour index, pixel count and result register.
// ----------------------------------------------------------------------------
module qoi_core #(
	parameter int DIMENSION_BITS = qoi_pkg::DIMENSION_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       restart,
	input  logic [2*DIMENSION_BITS-1:0] total_pixels,
	input  logic                       item_valid,
	input  qoi_pkg::in_item_t          item,
	output logic                       item_ready,
	output logic                       empty,
	input  logic                       pop,
	output qoi_pkg::out_item_t         result
);
	import qoi_pkg::*;

	logic [7:0]  col_q [4];
	logic [63:0] idx_valid_q;
	logic [15:0] pend_q;
	logic [2:0]  need_q;
	logic [31:0] remain_q;
	logic        fin_q;
	logic        out_valid_q;
	out_item_t   out_q;
	logic        valid_s1;
	in_item_t    item_s1;
	logic [5:0]  lw_addr_q;
	logic [31:0] lw_data_q;
	logic        lw_valid_q;

	logic [7:0]  b;
	logic [7:0]  op;
	logic [7:0]  nc [4];
	logic [15:0] npend;
	logic [2:0]  nneed;
	logic        do_emit, do_err;
	logic [31:0] count, rep, nremain;
	logic [5:0]  h, ri;
	logic [2:0]  nbits;
	logic [15:0] merged;
	logic        load, advance, commit, idx_we;
	logic [31:0] ram_rdata, recall;

	function automatic logic [7:0] sx(input logic [7:0] v, input int bits);
		logic [7:0] m;
		m = 8'(1) << (bits - 1);
		return ((v & ((m << 1) - 8'd1)) ^ m) - m;
	endfunction

	// The index read is issued as an entry moves into the staging register, so
	// the data is ready when that entry is decoded. The most recent index write
	// is kept aside because it may land on the same edge as the read.
	assign advance    = valid_s1 && (!out_valid_q || pop);
	assign commit     = advance && !fin_q;
	assign item_ready = !valid_s1 || advance;
	assign load       = item_valid && item_ready;
	assign idx_we     = commit && do_emit;
	assign empty      = !out_valid_q;
	assign result     = out_q;
	assign b          = item_s1.data_byte;
	assign op         = pend_q[7:0];
	assign ri         = b[5:0];
	assign recall     = (lw_valid_q && lw_addr_q == ri) ? lw_data_q : ram_rdata;
	assign nbits      = 3'(b[3]) + 3'(b[2]) + 3'(b[1]) + 3'(b[0]);
	assign merged     = {pend_q[15:8], b};

	qoi_ram #(.WIDTH(32), .DEPTH(INDEX_ENTRIES_DEF)) u_index (
		.clk(clk), .we(idx_we), .waddr(h), .wdata({nc[0], nc[1], nc[2], nc[3]}),
		.re(load), .raddr(item.data_byte[5:0]), .rdata(ram_rdata)
	);

	always_comb begin
		for (int k = 0; k < 4; k++) nc[k] = col_q[k];
		npend = pend_q; nneed = need_q; do_emit = 1'b0; do_err = 1'b0;
		count = 32'd1;
		if (item_s1.end_marker) begin
			if (need_q != 3'd0) begin
				do_err = 1'b1; nneed = 3'd0;
			end else begin
				do_emit = 1'b1; count = remain_q;
			end
		end else if (need_q == 3'd0) begin
			if (b[7:6] == 2'b00) begin
				if (idx_valid_q[ri])
					for (int k = 0; k < 4; k++) nc[k] = recall[31-8*k -: 8];
				else
					for (int k = 0; k < 4; k++) nc[k] = 8'd0;
				do_emit = 1'b1;
			end else if (b[7:5] == 3'b010) begin
				do_emit = 1'b1; count = 32'(b[4:0]) + 32'd1;
			end else if (b[7:6] == 2'b10) begin
				nc[0] = col_q[0] + sx(8'(b >> 4), 2);
				nc[1] = col_q[1] + sx(8'(b >> 2), 2);
				nc[2] = col_q[2] + sx(b, 2);
				do_emit = 1'b1;
			end else if (b[7:5] == 3'b011 || b[7:5] == 3'b110) begin
				npend = {8'd0, b}; nneed = 3'd1;
			end else if (b[7:4] == 4'hE) begin
				npend = {8'd0, b}; nneed = 3'd2;
			end else if (nbits == 3'd0) begin
				do_emit = 1'b1;
			end else begin
				npend = {8'd0, b}; nneed = nbits;
			end
		end else begin
			if (op[7:5] == 3'b011) begin
				nneed = 3'd0; do_emit = 1'b1;
				count = 32'({op[4:0], b}) + 32'd33;
			end else if (op[7:5] == 3'b110) begin
				nneed = 3'd0; do_emit = 1'b1;
				nc[0] = col_q[0] + sx(op, 5);
				nc[1] = col_q[1] + sx(8'(b >> 4), 4);
				nc[2] = col_q[2] + sx(b, 4);
			end else if (op[7:4] == 4'hE) begin
				if (need_q >= 3'd2) begin
					npend = {b, op}; nneed = 3'd1;
				end else begin
					nneed = 3'd0; do_emit = 1'b1;
					nc[0] = col_q[0] + sx(8'({op[3:0], merged[15]}), 5);
					nc[1] = col_q[1] + sx(8'(merged[14:10]), 5);
					nc[2] = col_q[2] + sx(8'(merged[9:5]), 5);
					nc[3] = col_q[3] + sx(8'(merged[4:0]), 5);
				end
			end else if (op[7:4] == 4'hF) begin
				if (op[3]) begin
					nc[0] = b; npend = {pend_q[15:8], op & 8'hF7};
				end else if (op[2]) begin
					nc[1] = b; npend = {pend_q[15:8], op & 8'hFB};
				end else if (op[1]) begin
					nc[2] = b; npend = {pend_q[15:8], op & 8'hFD};
				end else if (op[0]) begin
					nc[3] = b; npend = {pend_q[15:8], op & 8'hFE};
				end
				nneed = need_q - 3'd1;
				if (nneed == 3'd0 || npend[3:0] == 4'd0) begin
					nneed = 3'd0; do_emit = 1'b1;
				end
			end else begin
				nneed = 3'd0;
			end
		end
		h       = nc[0][5:0] ^ nc[1][5:0] ^ nc[2][5:0] ^ nc[3][5:0];
		rep     = (count < remain_q) ? count : remain_q;
		nremain = remain_q - rep;
	end

	always_ff @(posedge clk) begin
		if (load) item_s1 <= item;
		if (commit) begin
			out_q.red   <= do_err ? 8'd0 : nc[0];
			out_q.green <= do_err ? 8'd0 : nc[1];
			out_q.blue  <= do_err ? 8'd0 : nc[2];
			out_q.alpha <= do_err ? 8'd0 : nc[3];
			out_q.repeat_count    <= do_err ? 32'd0 : rep;
			out_q.image_complete  <= !do_err && (nremain == 32'd0);
			out_q.truncated_error <= do_err;
			pend_q <= npend;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q[0] <= 8'd0; col_q[1] <= 8'd0; col_q[2] <= 8'd0; col_q[3] <= 8'hFF;
			idx_valid_q <= '0; need_q <= 3'd0; remain_q <= 32'd1; fin_q <= 1'b0;
			out_valid_q <= 1'b0; valid_s1 <= 1'b0;
			lw_valid_q <= 1'b0; lw_addr_q <= '0; lw_data_q <= '0;
		end else if (restart) begin
			col_q[0] <= 8'd0; col_q[1] <= 8'd0; col_q[2] <= 8'd0; col_q[3] <= 8'hFF;
			idx_valid_q <= '0; need_q <= 3'd0;
			remain_q <= 32'(total_pixels); fin_q <= (total_pixels == '0);
			out_valid_q <= 1'b0; valid_s1 <= 1'b0; lw_valid_q <= 1'b0;
		end else begin
			out_valid_q <= (out_valid_q && !pop) || (commit && (do_emit || do_err));
			if (load) valid_s1 <= 1'b1;
			else if (advance) valid_s1 <= 1'b0;
			if (commit) begin
				for (int k = 0; k < 4; k++) col_q[k] <= nc[k];
				need_q <= nneed;
				if (do_emit) begin
					idx_valid_q[h] <= 1'b1;
					remain_q <= nremain;
				end
				if ((do_emit && nremain == 32'd0) || do_err) fin_q <= 1'b1;
			end
			if (idx_we) begin
				lw_valid_q <= 1'b1;
				lw_addr_q  <= h;
				lw_data_q  <= {nc[0], nc[1], nc[2], nc[3]};
			end
		end
	end
endmodule

// ----------------------------------------------------------------------------
// qoi_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module qoi_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	assign rdata = rdata_q;

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		if (re) rdata_q <= mem_q[raddr];
	end
endmodule

// ===== hdl/qoi_variant_pixel_decoder.sv =====
// ----------------------------------------------------------------------------
// qoi_variant_pixel_decoder
// Decodes QOI-like pixel bytes into colour runs.
// ----------------------------------------------------------------------------
// While full is low, one byte or end marker is accepted per cycle into a
// two-entry input queue. The decode core moves the queue head into a staging
// register, where the colour index read completes, and decodes one entry per
// cycle unless a result is waiting, limited by the current colour update.
// A result passes from the queue through the staging register into the output
// register and sits there until popped; a waiting result stalls the core.
// Writing either dimension register flushes all state and starts a new image;
// full stays high while the restart passes through restart_s1 and restart_s2.
// Write only while idle.
module qoi_variant_pixel_decoder #(
	parameter int DIMENSION_BITS = qoi_pkg::DIMENSION_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [qoi_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [qoi_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                        push,
	input  qoi_pkg::in_item_t           in_item,
	output logic                        full,
	output logic                        empty,
	input  logic                        pop,
	output qoi_pkg::out_item_t          out_item
);
	import qoi_pkg::*;

	logic [DIMENSION_BITS-1:0]   width_q, height_q;
	logic [2*DIMENSION_BITS-1:0] prod_s1;
	logic                        restart_s1, restart_s2;
	logic                        f_empty, f_full, core_ready;
	in_item_t                    f_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= DIMENSION_BITS'(1); height_q <= DIMENSION_BITS'(1);
			restart_s1 <= 1'b0; restart_s2 <= 1'b0;
		end else begin
			restart_s1 <= cfg_we;
			restart_s2 <= restart_s1;
			if (cfg_we) begin
				if (cfg_addr == REG_WIDTH)  width_q  <= cfg_wdata[DIMENSION_BITS-1:0];
				if (cfg_addr == REG_HEIGHT) height_q <= cfg_wdata[DIMENSION_BITS-1:0];
			end
		end
	end

	// The product is registered so the multiplier sits alone between flops. The
	// restart is taken from restart_s2 so the core sees the new product.
	always_ff @(posedge clk) begin
		prod_s1 <= width_q * height_q;
	end

	assign full = f_full || restart_s1 || restart_s2;

	qoi_fifo #(.WIDTH($bits(in_item_t))) u_fifo (
		.clk(clk), .arst_n(arst_n), .flush(restart_s2),
		.push(push && !restart_s1 && !restart_s2), .wdata(in_item), .full(f_full),
		.pop(core_ready), .empty(f_empty), .rdata(f_item)
	);

	qoi_core #(.DIMENSION_BITS(DIMENSION_BITS)) u_core (
		.clk(clk), .arst_n(arst_n), .restart(restart_s2), .total_pixels(prod_s1),
		.item_valid(!f_empty), .item(f_item), .item_ready(core_ready),
		.empty(empty), .pop(pop), .result(out_item)
	);
endmodule

// ===== hdl/qoi_checker.sv =====
// ----------------------------------------------------------------------------
// qoi_checker
// Port-level checks on the decoder's result queue.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module qoi_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               empty,
	input logic               pop,
	input qoi_pkg::out_item_t out_item
);
	logic show_err;

	assign show_err = !empty && out_item.truncated_error;

	`ASSERT_CLK(a_hold, clk, arst_n, (!empty && !pop) |=> !empty, "result dropped")
	`ASSERT_CLK(a_stable, clk, arst_n, (!empty && !pop) |=> $stable(out_item), "result changed")
	`ASSERT_CLK(a_err_zero, clk, arst_n, show_err |-> out_item.repeat_count == '0, "error count")
	`ASSERT_NEVER(a_err_nc, clk, arst_n, show_err && out_item.image_complete, "error complete")
endmodule

bind qoi_variant_pixel_decoder qoi_checker u_chk (
	.clk(clk), .arst_n(arst_n), .empty(empty), .pop(pop), .out_item(out_item)
);
